// ===== rtl/spq_pkg.sv =====
// Shared constants and types for the sorted priority queue.
`default_nettype none

package spq_pkg;

  // Number of cells in the row.
  localparam int unsigned DEPTH = 8;

  // Width of the fill count, which must hold DEPTH itself.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Field widths of the payload.
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ECNT_W   = 4;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // Command broadcast to every cell in the cycle of an accepted beat.
  typedef struct packed {
    logic                    ins_en;
    logic                    del_en;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  // Signals that ripple from a cell to its right-hand neighbor.
  typedef struct packed {
    logic place;  // this cell is at or past the insert point
    logic hit;    // a matching entry sits at this cell or to its left
  } link_t;

endpackage

`default_nettype wire

// ===== rtl/spq_in_if.sv =====
// Input channel of the sorted priority queue: operation and value.
`default_nettype none

interface spq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic signed [spq_pkg::VAL_W-1:0]     value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/spq_out_if.sv =====
// Result channel of the sorted priority queue: status, count and head.
`default_nettype none

interface spq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [spq_pkg::STATUS_W-1:0]         status;
  logic [spq_pkg::ECNT_W-1:0]           entry_count;
  logic signed [spq_pkg::VAL_W-1:0]     head_value;

  modport source (output valid, output status, output entry_count, output head_value,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input head_value,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One cell of the sorted row: holds an entry, compares it and shifts with its neighbors.
`default_nettype none

module spq_cell (
  input  wire logic                            clk,
  input  wire spq_pkg::cmd_t                   cmd,
  input  wire logic                            occupied,
  input  wire spq_pkg::link_t                  link_in,
  input  wire logic signed [spq_pkg::VAL_W-1:0] left_value,
  input  wire logic signed [spq_pkg::VAL_W-1:0] right_value,
  output spq_pkg::link_t                       link_out,
  output logic signed [spq_pkg::VAL_W-1:0]     value_r,
  output logic signed [spq_pkg::VAL_W-1:0]     value_nxt
);

  logic place;
  logic match;

  // An empty cell, or one whose entry is not greater than the new value, is a
  // candidate slot; the row is sorted, so the first such cell is the insert point.
  assign place = !occupied || (cmd.value >= value_r);

  // Delete looks for the first occupied cell that holds the value.
  assign match = occupied && (value_r == cmd.value);

  assign link_out = '{place: place, hit: (link_in.hit || match)};

  // Insert moves entries right from the insert point; delete moves them left
  // from the first match onward.
  always_comb begin
    value_nxt = value_r;
    if (cmd.ins_en) begin
      if (link_in.place) begin
        value_nxt = left_value;
      end else if (place) begin
        value_nxt = cmd.value;
      end
    end else if (cmd.del_en && link_out.hit) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: fill count, row of cells and result register.
`default_nettype none

// The queue keeps up to spq_pkg::DEPTH signed 32-bit values in descending
// order, one value per cell, with the largest in cell 0. An insert lands ahead
// of the first stored value that is not greater than it; a delete removes the
// first stored entry equal to the value and closes the gap. Every input beat
// gives exactly one result beat carrying the status, the new count and the head
// (zero when empty). A beat is accepted in every cycle as long as the result
// register is free or being read in that cycle, and its result is registered
// there and appears in the cycle after acceptance. The row updates as a whole:
// every cell compares against the broadcast value and loads from itself,
// a neighbor or the input at once, and the delete match ripples along the row.
module sorted_priority_queue_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spq_in_if.sink     in_chan,
  spq_out_if.source  out_chan
);

  localparam int unsigned DEPTH = spq_pkg::DEPTH;
  localparam int unsigned CNT_W = spq_pkg::CNT_W;
  localparam int unsigned VAL_W = spq_pkg::VAL_W;

  logic [CNT_W-1:0]                count_r;
  logic [CNT_W-1:0]                count_nxt;
  logic                            out_valid_r;
  logic [spq_pkg::STATUS_W-1:0]    status_r;
  logic [spq_pkg::STATUS_W-1:0]    status_nxt;
  logic [spq_pkg::ECNT_W-1:0]      ecount_r;
  logic signed [VAL_W-1:0]         head_r;
  logic signed [VAL_W-1:0]         head_nxt;

  logic                            accept;
  logic                            is_full;
  logic                            is_empty;
  logic                            found;
  spq_pkg::cmd_t                   cmd;

  spq_pkg::link_t                  link [DEPTH+1];
  logic signed [VAL_W-1:0]         cell_value [DEPTH];
  logic signed [VAL_W-1:0]         cell_next  [DEPTH];

  // Handshake: the result register parts the two sides.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  // Command broadcast to the row; a refused insert changes nothing.
  always_comb begin
    cmd.value  = in_chan.value;
    cmd.ins_en = accept && (in_chan.opcode == spq_pkg::OP_INSERT) && !is_full;
    cmd.del_en = accept && (in_chan.opcode == spq_pkg::OP_DELETE);
  end

  // The left end of the row has no neighbor to pull from or match against.
  assign link[0] = '0;

  // Row of cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = cell_value[i];
    end else begin : g_inner_l
      assign left_v = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_v = cell_value[i];
    end else begin : g_inner_r
      assign right_v = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (count_r > CNT_W'(i)),
      .link_in     (link[i]),
      .left_value  (left_v),
      .right_value (right_v),
      .link_out    (link[i+1]),
      .value_r     (cell_value[i]),
      .value_nxt   (cell_next[i])
    );
  end

  assign found = link[DEPTH].hit;

  // Count and status for the beat being accepted.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_OK;
    if (in_chan.opcode == spq_pkg::OP_INSERT) begin
      if (is_full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (is_empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else if (!found) begin
        status_nxt = spq_pkg::ST_NOT_FOUND;
      end else begin
        count_nxt = count_r - 1'b1;
      end
    end
    head_nxt = (count_nxt == '0) ? '0 : cell_next[0];
  end

  // Fill count and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      ecount_r <= spq_pkg::ECNT_W'(count_nxt);
      head_r   <= head_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = status_r;
  assign out_chan.entry_count = ecount_r;
  assign out_chan.head_value  = head_r;

  // The fill count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // A successful insert grows the queue by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_en |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the queue");

  // A delete that finds nothing leaves the count alone.
  a_miss_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.del_en && !found) |=> $stable(count_r))
    else $error("missed delete changed the count");

  // The two front entries stay in descending order.
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (cell_value[0] >= cell_value[1]))
    else $error("front entries out of order");

endmodule

`default_nettype wire

// ===== tb/sorted_priority_queue_top_tb.sv =====
// Self-checking testbench for the sorted priority queue top level.
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;

  localparam logic signed [spq_pkg::VAL_W-1:0] MAX_VAL = 32'sh7fff_ffff;
  localparam logic signed [spq_pkg::VAL_W-1:0] MIN_VAL = 32'sh8000_0000;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // One result beat as the block should produce it.
  typedef struct packed {
    logic [spq_pkg::STATUS_W-1:0]     status;
    logic [spq_pkg::ECNT_W-1:0]       count;
    logic signed [spq_pkg::VAL_W-1:0] head;
  } queue_result_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_chan ();
  spq_out_if out_chan ();

  sorted_priority_queue_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow copy of the stored row, kept in descending order.
  logic signed [spq_pkg::VAL_W-1:0] queue_vals [spq_pkg::DEPTH];
  int                               queue_fill;

  queue_result_t pending_results [$];
  int            error_count;
  int unsigned   cycle_count;
  logic          src_gaps_on;
  logic          sink_stalls_on;

  // Clock.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Run timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("sorted_priority_queue_top_tb failed");
      $finish;
    end
  end

  // Apply one operation to the shadow row and return the result it gives.
  function automatic queue_result_t sorted_queue_update(
      input logic op, input logic signed [spq_pkg::VAL_W-1:0] val);
    queue_result_t r;
    int            pos;
    int            k;
    r.status = spq_pkg::ST_OK;
    if (op == spq_pkg::OP_INSERT) begin
      if (queue_fill >= spq_pkg::DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // The new value goes ahead of the first entry that is not greater.
        pos = queue_fill;
        for (k = queue_fill - 1; k >= 0; k--) begin
          if (val >= queue_vals[k]) pos = k;
        end
        for (k = queue_fill; k > pos; k--) queue_vals[k] = queue_vals[k-1];
        queue_vals[pos] = val;
        queue_fill++;
      end
    end else begin
      if (queue_fill == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        pos = -1;
        for (k = 0; k < queue_fill; k++) begin
          if (pos < 0 && queue_vals[k] == val) pos = k;
        end
        if (pos < 0) begin
          r.status = spq_pkg::ST_NOT_FOUND;
        end else begin
          // Close the gap left by the removed entry.
          for (k = pos; k + 1 < queue_fill; k++) queue_vals[k] = queue_vals[k+1];
          queue_fill--;
        end
      end
    end
    r.count = spq_pkg::ECNT_W'(queue_fill);
    r.head  = (queue_fill > 0) ? queue_vals[0] : '0;
    return r;
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 60) return $urandom_range(2, 1);
    if (pick < 90) return $urandom_range(6, 3);
    return $urandom_range(40, 12);
  endfunction

  // Value mix: a small pool so that deletes hit, values near the extremes, and full range.
  function automatic logic signed [spq_pkg::VAL_W-1:0] pick_value();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 45) return spq_pkg::VAL_W'($urandom_range(8, 0)) - 32'sd4;
    if (pick < 52) return MAX_VAL - spq_pkg::VAL_W'($urandom_range(2, 0));
    if (pick < 60) return MIN_VAL + spq_pkg::VAL_W'($urandom_range(2, 0));
    return $urandom;
  endfunction

  // Send one beat, with an optional gap ahead of it, and record its result.
  task automatic send_op(input logic op, input logic signed [spq_pkg::VAL_W-1:0] val);
    int gap;
    gap = 0;
    if (src_gaps_on && $urandom_range(99, 0) >= 55) gap = idle_length();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.opcode <= op;
    in_chan.value  <= val;
    do @(posedge clk); while (!in_chan.ready);
    pending_results.push_back(sorted_queue_update(op, val));
  endtask

  // Hold the source off until every outstanding result has been taken.
  task automatic wait_for_drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Random operation, steered by fill level so the queue wanders between empty and full.
  task automatic send_random_op();
    logic                             op;
    logic signed [spq_pkg::VAL_W-1:0] val;
    int                               pick;
    pick = $urandom_range(99, 0);
    if (queue_fill == 0)
      op = (pick < 75) ? spq_pkg::OP_INSERT : spq_pkg::OP_DELETE;
    else if (queue_fill >= spq_pkg::DEPTH)
      op = (pick < 35) ? spq_pkg::OP_INSERT : spq_pkg::OP_DELETE;
    else
      op = (pick < 50) ? spq_pkg::OP_INSERT : spq_pkg::OP_DELETE;
    if (op == spq_pkg::OP_DELETE && queue_fill > 0 && $urandom_range(99, 0) < 75)
      val = queue_vals[$urandom_range(queue_fill - 1, 0)];
    else
      val = pick_value();
    send_op(op, val);
  endtask

  // Result sink: random back-pressure, or none in quiet phases.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      if (sink_stalls_on && $urandom_range(99, 0) < 30) begin
        out_chan.ready <= 1'b0;
        repeat (idle_length()) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
    end
  end

  // Compare each result beat with the oldest outstanding result.
  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual status %0d count %0d head %0d",
                 $time, out_chan.status, out_chan.entry_count, out_chan.head_value);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_chan.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_chan.status);
          error_count++;
        end
        if (out_chan.entry_count !== want.count) begin
          $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                   $time, want.count, out_chan.entry_count);
          error_count++;
        end
        if (out_chan.head_value !== want.head) begin
          $display("%0t: head_value mismatch: expected %0d, actual %0d",
                   $time, want.head, out_chan.head_value);
          error_count++;
        end
      end
    end
  end

  // Extremes, every status, duplicates, full and empty queue, zero head when empty.
  task automatic test_directed();
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    send_op(spq_pkg::OP_DELETE, 32'sd0);
    send_op(spq_pkg::OP_DELETE, MIN_VAL);
    send_op(spq_pkg::OP_INSERT, MIN_VAL);
    send_op(spq_pkg::OP_INSERT, MAX_VAL);
    send_op(spq_pkg::OP_INSERT, 32'sd0);
    send_op(spq_pkg::OP_INSERT, -32'sd1);
    send_op(spq_pkg::OP_INSERT, -32'sd1);
    send_op(spq_pkg::OP_INSERT, 32'sd5);
    send_op(spq_pkg::OP_INSERT, MAX_VAL);
    send_op(spq_pkg::OP_INSERT, MIN_VAL);
    send_op(spq_pkg::OP_INSERT, 32'sd7);
    send_op(spq_pkg::OP_INSERT, MIN_VAL);
    send_op(spq_pkg::OP_DELETE, 32'sd3);
    send_op(spq_pkg::OP_DELETE, MAX_VAL);
    send_op(spq_pkg::OP_DELETE, -32'sd1);
    send_op(spq_pkg::OP_DELETE, MIN_VAL);
    send_op(spq_pkg::OP_DELETE, MIN_VAL);
    send_op(spq_pkg::OP_DELETE, MAX_VAL);
    send_op(spq_pkg::OP_DELETE, 32'sd5);
    send_op(spq_pkg::OP_DELETE, 32'sd0);
    send_op(spq_pkg::OP_DELETE, -32'sd1);
    send_op(spq_pkg::OP_DELETE, -32'sd1);
    wait_for_drain();
  endtask

  // Random traffic with idling on both sides.
  task automatic test_random_traffic(input int n_items);
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    repeat (n_items) send_random_op();
    wait_for_drain();
  endtask

  // Full rate in both directions.
  task automatic test_back_to_back(input int n_items);
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (n_items) send_random_op();
    wait_for_drain();
  endtask

  // Steady source against a stalling sink.
  task automatic test_slow_sink(input int n_items);
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b1;
    repeat (n_items) send_random_op();
    wait_for_drain();
  endtask

  // Bursty source against an always-ready sink.
  task automatic test_bursty_source(input int n_items);
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b0;
    repeat (n_items) send_random_op();
  endtask

  initial begin
    error_count    = 0;
    cycle_count    = 0;
    queue_fill     = 0;
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    for (int k = 0; k < spq_pkg::DEPTH; k++) queue_vals[k] = '0;
    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.opcode <= spq_pkg::OP_INSERT;
    in_chan.value  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic(700);
    test_back_to_back(400);
    test_slow_sink(220);
    test_bursty_source(210);

    // Let the last results arrive, then keep watching for stray beats.
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("sorted_priority_queue_top_tb passed");
    end else begin
      $display("sorted_priority_queue_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== sorted_priority_queue_top.f =====
rtl/spq_pkg.sv
rtl/spq_in_if.sv
rtl/spq_out_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
tb/sorted_priority_queue_top_tb.sv
